/* src/aging_client_address_table_defines.svh */
// assertion macros for the aging client address table
// expects i_clk and i_rst_n in the scope of use
`ifndef AGING_CLIENT_ADDRESS_TABLE_DEFINES_SVH
`define AGING_CLIENT_ADDRESS_TABLE_DEFINES_SVH

// same-cycle implication
`define ACAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ACAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/acat_pkg.sv */
// shared constants, codes and types for the aging client address table
// no dependencies
`timescale 1ns / 1ps

package acat_pkg;

    localparam int MAX_CLIENTS = 16;
    localparam int IDX_W       = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CNT_W       = $clog2(MAX_CLIENTS + 1);
    localparam int ADDR_W      = 32;
    localparam int LIFE_W      = 8;
    localparam int ID_W        = 5;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [LIFE_W-1:0]    LIFETIME_RESET = LIFE_W'(20);
    localparam logic [PADDR_W-3:0]   REG_LIFETIME   = '0;

    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    typedef enum logic [1:0] {
        ST_REFRESH = 2'd0,
        ST_APPEND  = 2'd1,
        ST_REUSE   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_REUSE,
        S_TICK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              addr_we;
        logic              life_we;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] addr;
        logic [LIFE_W-1:0] life;
    } t_store_wr;

    typedef struct packed {
        logic              addr_eq;
        logic              life_zero;
        logic [LIFE_W-1:0] life_dec;
    } t_cmp_res;

endpackage

/* src/aging_client_address_table.sv */
// aging client address table top level: apb lifetime register and submodules
// depends on acat_pkg, acat_ctrl, acat_entry_store, acat_cmp_unit
//
//   channel   | handshake          | payload
//   ----------+--------------------+--------------------------------
//   request   | i_valid / o_stall  | i_operation, i_ip_address
//   result    | o_valid / i_stall  | o_client_id, o_status
//   config    | psel, penable      | paddr, pwdata, prdata
//
// a register request scans the filled slots for a hit, else appends if there is room,
// else rescans from slot 0 for an expired slot; a tick decrements each nonzero lifetime
// one entry is compared or decremented per cycle by the shared compare unit
// reset clears the fill count, the sequencer and the result valid flag; lifetime goes to 20
// a held result stalls only the hand-over from the finished request, not the scan
`timescale 1ns / 1ps

module aging_client_address_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_operation,
    input  logic [acat_pkg::ADDR_W-1:0]    i_ip_address,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [acat_pkg::ID_W-1:0]      o_client_id,
    output logic [1:0]                     o_status,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [acat_pkg::PADDR_W-1:0]   paddr,
    input  logic [acat_pkg::PDATA_W-1:0]   pwdata,
    output logic [acat_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import acat_pkg::*;

    logic [LIFE_W-1:0] r_lifetime, n_lifetime;
    logic              sel_lifetime;
    logic              cfg_we;

    t_cmp_res          cmp_res;
    t_store_wr         store_wr;
    logic [ADDR_W-1:0] req_addr;
    logic [IDX_W-1:0]  rd_idx;
    logic [ADDR_W-1:0] rd_addr;
    logic [LIFE_W-1:0] rd_life;

    assign pready       = 1'b1;
    assign sel_lifetime = (paddr[PADDR_W-1:2] == REG_LIFETIME);
    assign cfg_we       = psel && penable && pwrite && pready;

    always_comb begin
        n_lifetime = r_lifetime;
        if (cfg_we && sel_lifetime) begin
            n_lifetime = pwdata[LIFE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= LIFETIME_RESET;
        end else begin
            r_lifetime <= n_lifetime;
        end
    end

    assign prdata = sel_lifetime ? PDATA_W'(r_lifetime) : '0;

    acat_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_ip_address (i_ip_address),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_client_id  (o_client_id),
        .o_status     (o_status),
        .i_lifetime   (r_lifetime),
        .i_cmp        (cmp_res),
        .o_req_addr   (req_addr),
        .o_rd_idx     (rd_idx),
        .o_wr         (store_wr)
    );

    acat_entry_store u_store (
        .i_clk     (i_clk),
        .i_wr      (store_wr),
        .i_rd_idx  (rd_idx),
        .o_rd_addr (rd_addr),
        .o_rd_life (rd_life)
    );

    acat_cmp_unit u_cmp (
        .i_entry_addr (rd_addr),
        .i_req_addr   (req_addr),
        .i_life       (rd_life),
        .o_res        (cmp_res)
    );

endmodule

/* src/acat_entry_store.sv */
// entry address and lifetime storage, one write port, one read index with registered read data
// depends on acat_pkg
`timescale 1ns / 1ps

module acat_entry_store (
    input  logic                          i_clk,
    input  acat_pkg::t_store_wr           i_wr,
    input  logic [acat_pkg::IDX_W-1:0]    i_rd_idx,
    output logic [acat_pkg::ADDR_W-1:0]   o_rd_addr,
    output logic [acat_pkg::LIFE_W-1:0]   o_rd_life
);
    import acat_pkg::*;

    logic [ADDR_W-1:0] r_addr_mem [MAX_CLIENTS];
    logic [LIFE_W-1:0] r_life_mem [MAX_CLIENTS];
    logic [ADDR_W-1:0] r_rd_addr;
    logic [LIFE_W-1:0] r_rd_life;

    always_ff @(posedge i_clk) begin
        if (i_wr.addr_we) begin
            r_addr_mem[i_wr.idx] <= i_wr.addr;
        end
        if (i_wr.life_we) begin
            r_life_mem[i_wr.idx] <= i_wr.life;
        end
        r_rd_addr <= r_addr_mem[i_rd_idx];
        r_rd_life <= r_life_mem[i_rd_idx];
    end

    assign o_rd_addr = r_rd_addr;
    assign o_rd_life = r_rd_life;

endmodule

/* src/acat_cmp_unit.sv */
// shared compare and decrement unit used by every scan step
// depends on acat_pkg
`timescale 1ns / 1ps

module acat_cmp_unit (
    input  logic [acat_pkg::ADDR_W-1:0] i_entry_addr,
    input  logic [acat_pkg::ADDR_W-1:0] i_req_addr,
    input  logic [acat_pkg::LIFE_W-1:0] i_life,
    output acat_pkg::t_cmp_res          o_res
);
    import acat_pkg::*;

    always_comb begin
        o_res.addr_eq   = (i_entry_addr == i_req_addr);
        o_res.life_zero = (i_life == '0);
        o_res.life_dec  = i_life - LIFE_W'(1);
    end

endmodule

/* src/acat_ctrl.sv */
// scan sequencer: search, append, reuse and tick passes plus result register
// depends on acat_pkg and aging_client_address_table_defines.svh
`timescale 1ns / 1ps
`include "aging_client_address_table_defines.svh"

module acat_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_operation,
    input  logic [acat_pkg::ADDR_W-1:0]   i_ip_address,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [acat_pkg::ID_W-1:0]     o_client_id,
    output logic [1:0]                    o_status,
    input  logic [acat_pkg::LIFE_W-1:0]   i_lifetime,
    input  acat_pkg::t_cmp_res            i_cmp,
    output logic [acat_pkg::ADDR_W-1:0]   o_req_addr,
    output logic [acat_pkg::IDX_W-1:0]    o_rd_idx,
    output acat_pkg::t_store_wr           o_wr
);
    import acat_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_req_addr, n_req_addr;
    logic [ID_W-1:0]   r_res_id, n_res_id;
    t_status           r_res_status, n_res_status;
    logic              r_out_valid, n_out_valid;
    logic [ID_W-1:0]   r_out_id, n_out_id;
    t_status           r_out_status, n_out_status;

    logic scan_end;
    logic has_room;
    logic out_free;

    assign scan_end = (r_idx == r_count);
    assign has_room = (r_count < CNT_W'(MAX_CLIENTS));
    assign out_free = !r_out_valid || !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_operation == OP_TICK) ? S_TICK : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (scan_end) begin
                    n_state = has_room ? S_DONE : S_REUSE;
                end else if (i_cmp.addr_eq) begin
                    n_state = S_DONE;
                end
            end
            S_REUSE: begin
                if (scan_end || i_cmp.life_zero) begin
                    n_state = S_DONE;
                end
            end
            S_TICK: begin
                if (scan_end) begin
                    n_state = S_IDLE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_idx        = r_idx;
        n_count      = r_count;
        n_req_addr   = r_req_addr;
        n_res_id     = r_res_id;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_stall;
        n_out_id     = r_out_id;
        n_out_status = r_out_status;
        o_wr.addr_we = 1'b0;
        o_wr.life_we = 1'b0;
        o_wr.idx     = r_idx[IDX_W-1:0];
        o_wr.addr    = r_req_addr;
        o_wr.life    = i_lifetime;
        case (r_state)
            S_IDLE: begin
                n_idx      = '0;
                n_req_addr = i_ip_address;
            end
            S_SEARCH: begin
                if (scan_end) begin
                    if (has_room) begin
                        o_wr.addr_we = 1'b1;
                        o_wr.life_we = 1'b1;
                        n_count      = r_count + CNT_W'(1);
                        n_res_id     = ID_W'(r_idx) + ID_W'(1);
                        n_res_status = ST_APPEND;
                    end else begin
                        n_idx = '0;
                    end
                end else if (i_cmp.addr_eq) begin
                    o_wr.life_we = 1'b1;
                    n_res_id     = ID_W'(r_idx) + ID_W'(1);
                    n_res_status = ST_REFRESH;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_REUSE: begin
                if (scan_end) begin
                    n_res_id     = '0;
                    n_res_status = ST_FULL;
                end else if (i_cmp.life_zero) begin
                    o_wr.addr_we = 1'b1;
                    o_wr.life_we = 1'b1;
                    n_res_id     = ID_W'(r_idx) + ID_W'(1);
                    n_res_status = ST_REUSE;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_TICK: begin
                if (!scan_end) begin
                    o_wr.life_we = !i_cmp.life_zero;
                    o_wr.life    = i_cmp.life_dec;
                    n_idx        = r_idx + CNT_W'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_id     = r_res_id;
                    n_out_status = r_res_status;
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_req_addr   <= n_req_addr;
        r_res_id     <= n_res_id;
        r_res_status <= n_res_status;
        r_out_id     <= n_out_id;
        r_out_status <= n_out_status;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_client_id = r_out_id;
    assign o_status    = r_out_status;
    assign o_req_addr  = r_req_addr;
    // store read is registered, so the index for the next scan step is presented
    assign o_rd_idx    = n_idx[IDX_W-1:0];

    `ACAT_ASSERT_NOW(a_full_id_zero, r_out_valid,
        (r_out_status == ST_FULL) == (r_out_id == '0),
        "client id zero must go with table full")
    `ACAT_ASSERT_NOW(a_reuse_when_full, r_state == S_REUSE,
        r_count == CNT_W'(MAX_CLIENTS),
        "reuse scan entered with free space")
    `ACAT_ASSERT_NEXT(a_count_step, 1'b1,
        (r_count == $past(r_count)) || (r_count == $past(r_count) + CNT_W'(1)),
        "fill count moved by more than one")

endmodule

/* tb/tb_aging_client_address_table.sv */
// self-checking testbench for the aging client address table: directed and random requests
// predicts ids and statuses from its table model or typed rows, ages the model on ticks
// depends on acat_pkg and aging_client_address_table
`timescale 1ns / 1ps

module tb_aging_client_address_table;
    import acat_pkg::*;

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 4;
    localparam int DRAIN_CYCLES    = 2 * MAX_CLIENTS + 8;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 141;
    localparam int POOL_SIZE       = 24;
    localparam int TICK_PCT        = 25;
    localparam int RUN_LIMIT_NS    = 2_000_000;

    localparam logic [PADDR_W-1:0] ADDR_LIFETIME = {REG_LIFETIME, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = {~REG_LIFETIME, 2'b00};

    typedef struct {
        logic              op;
        logic [ADDR_W-1:0] addr;
        bit                typed;
        logic [ID_W-1:0]   id;
        t_status           status;
    } t_request_row;

    typedef struct {
        logic [ID_W-1:0] id;
        t_status         status;
    } t_client_result;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_valid      = 1'b0;
    logic                o_stall;
    logic                i_operation  = OP_REGISTER;
    logic [ADDR_W-1:0]   i_ip_address = '0;
    logic                o_valid;
    logic                i_stall      = 1'b0;
    logic [ID_W-1:0]     o_client_id;
    logic [1:0]          o_status;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [PDATA_W-1:0]  pwdata       = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // table model
    logic [ADDR_W-1:0]   tbl_addr [MAX_CLIENTS];
    logic [LIFE_W-1:0]   tbl_life [MAX_CLIENTS];
    int                  tbl_fill     = 0;
    logic [LIFE_W-1:0]   cur_lifetime = LIFETIME_RESET;

    t_request_row        request_log[$];
    t_client_result      pending_results[$];
    t_request_row        directed_rows[$];
    logic [ADDR_W-1:0]   addr_pool [POOL_SIZE];
    int                  lifetime_plan [RANDOM_PHASES];

    int                  send_idle_pct = 0;
    int                  stall_pct     = 0;
    int                  errors        = 0;
    int                  requests_seen = 0;
    int                  ticks_seen    = 0;
    int                  status_seen [4];

    aging_client_address_table u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_ip_address (i_ip_address),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_client_id  (o_client_id),
        .o_status     (o_status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        errors++;
    endtask

    function automatic t_client_result register_client(input logic [ADDR_W-1:0] addr);
        t_client_result r;
        int slot;
        slot = -1;
        for (int i = 0; i < tbl_fill; i++) begin
            if (slot < 0 && tbl_addr[i] == addr) begin
                slot = i;
            end
        end
        if (slot >= 0) begin
            tbl_life[slot] = cur_lifetime;
            r.id = ID_W'(slot + 1);
            r.status = ST_REFRESH;
            return r;
        end
        if (tbl_fill < MAX_CLIENTS) begin
            tbl_addr[tbl_fill] = addr;
            tbl_life[tbl_fill] = cur_lifetime;
            tbl_fill++;
            r.id = ID_W'(tbl_fill);
            r.status = ST_APPEND;
            return r;
        end
        // full table: lowest expired slot is taken over
        for (int i = 0; i < tbl_fill; i++) begin
            if (slot < 0 && tbl_life[i] == '0) begin
                slot = i;
            end
        end
        if (slot >= 0) begin
            tbl_addr[slot] = addr;
            tbl_life[slot] = cur_lifetime;
            r.id = ID_W'(slot + 1);
            r.status = ST_REUSE;
            return r;
        end
        r.id = '0;
        r.status = ST_FULL;
        return r;
    endfunction

    function automatic void age_table();
        for (int i = 0; i < tbl_fill; i++) begin
            if (tbl_life[i] != '0) begin
                tbl_life[i] = tbl_life[i] - 1'b1;
            end
        end
    endfunction

    function automatic logic [ADDR_W-1:0] next_address();
        int pick;
        logic [ADDR_W-1:0] fresh;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        if (pick < 70) begin
            case ($urandom_range(0, 2))
                0: return '0;
                1: return '1;
                default: return ADDR_W'(1) << $urandom_range(0, ADDR_W - 1);
            endcase
        end
        fresh = $urandom();
        // keep some new addresses around so that reused slots get hit later
        if ($urandom_range(0, 1) == 0) begin
            addr_pool[$urandom_range(0, POOL_SIZE - 1)] = fresh;
        end
        return fresh;
    endfunction

    always @(posedge i_clk) begin
        t_request_row req;
        t_client_result want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    flag_error($sformatf("result with nothing outstanding: id %0d status %0d",
                                         o_client_id, o_status));
                end else begin
                    want = pending_results.pop_front();
                    if (o_client_id !== want.id) begin
                        flag_error($sformatf("client_id %0d, expected %0d",
                                             o_client_id, want.id));
                    end
                    if (o_status !== want.status) begin
                        flag_error($sformatf("status %0d, expected %0d (%s)",
                                             o_status, want.status, want.status.name()));
                    end
                end
            end
            if (i_valid && !o_stall) begin
                requests_seen++;
                if (request_log.size() != 0) begin
                    req = request_log.pop_front();
                end else begin
                    req = '{status: ST_REFRESH, default: '0};
                end
                if (i_operation == OP_TICK) begin
                    age_table();
                    ticks_seen++;
                end else begin
                    want = register_client(i_ip_address);
                    if (req.typed) begin
                        want = '{req.id, req.status};
                    end
                    pending_results.push_back(want);
                    status_seen[want.status]++;
                end
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input t_request_row req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_operation  <= req.op;
        i_ip_address <= req.addr;
        i_valid      <= 1'b1;
        request_log.push_back(req);
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic reg_access(input bit wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_LIFETIME) begin
            if (wr) begin
                cur_lifetime = data[LIFE_W-1:0];
            end else if (prdata[LIFE_W-1:0] !== cur_lifetime) begin
                flag_error($sformatf("lifetime reads %0d, expected %0d",
                                     prdata[LIFE_W-1:0], cur_lifetime));
            end
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        t_request_row req;
        logic [PDATA_W-1:0] wdata;
        for (int i = 0; i < MAX_CLIENTS; i++) begin
            tbl_addr[i] = '0;
            tbl_life[i] = '0;
        end
        for (int i = 0; i < 4; i++) begin
            status_seen[i] = 0;
        end
        for (int i = 0; i < POOL_SIZE; i++) begin
            addr_pool[i] = $urandom();
        end
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        lifetime_plan = '{3, 1, 0, 255, 2, 5, 1, 40};

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed requests with the reset lifetime
        directed_rows.push_back('{OP_REGISTER, 32'h0000_0000, 1'b1, 5'd1, ST_APPEND});
        directed_rows.push_back('{OP_REGISTER, 32'hFFFF_FFFF, 1'b1, 5'd2, ST_APPEND});
        directed_rows.push_back('{OP_REGISTER, 32'h0000_0000, 1'b1, 5'd1, ST_REFRESH});
        directed_rows.push_back('{OP_TICK,     32'hA5A5_A5A5, 1'b0, 5'd0, ST_REFRESH});
        directed_rows.push_back('{OP_REGISTER, 32'hFFFF_FFFF, 1'b1, 5'd2, ST_REFRESH});
        for (int i = 3; i <= MAX_CLIENTS; i++) begin
            directed_rows.push_back('{OP_REGISTER, 32'h0000_1000 << i, 1'b1,
                                      ID_W'(i), ST_APPEND});
        end
        directed_rows.push_back('{OP_REGISTER, 32'h5A5A_C3C3, 1'b1, 5'd0, ST_FULL});
        directed_rows.push_back('{OP_TICK,     32'h0000_0000, 1'b0, 5'd0, ST_REFRESH});
        directed_rows.push_back('{OP_REGISTER, 32'h0000_8000, 1'b0, 5'd0, ST_REFRESH});
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i]);
        end
        i_valid <= 1'b0;
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            send_idle_pct = 0;
            stall_pct = 0;
            wdata = $urandom();
            wdata[LIFE_W-1:0] = LIFE_W'(lifetime_plan[p]);
            reg_access(1'b1, ADDR_LIFETIME, wdata);
            reg_access(1'b1, ADDR_UNMAPPED, $urandom());
            reg_access(1'b0, ADDR_LIFETIME, '0);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 55; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 55; end
                default: begin send_idle_pct = 35; stall_pct = 35; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                req.op     = ($urandom_range(0, 99) < TICK_PCT) ? OP_TICK : OP_REGISTER;
                req.addr   = next_address();
                req.typed  = 1'b0;
                req.id     = '0;
                req.status = ST_REFRESH;
                send_request(req);
            end
            i_valid <= 1'b0;
            wait_idle();
        end

        $display("%0d requests over %0d lifetime settings, %0d of them ticks",
                 requests_seen, RANDOM_PHASES + 1, ticks_seen);
        $display("results: %0d refreshed, %0d appended, %0d reused, %0d table full",
                 status_seen[ST_REFRESH], status_seen[ST_APPEND],
                 status_seen[ST_REUSE], status_seen[ST_FULL]);
        if (errors == 0) begin
            $display("tb_aging_client_address_table passed");
        end else begin
            $display("tb_aging_client_address_table failed");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("tb_aging_client_address_table failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/acat_pkg.sv
src/acat_entry_store.sv
src/acat_cmp_unit.sv
src/acat_ctrl.sv
src/aging_client_address_table.sv
tb/tb_aging_client_address_table.sv
